/* rtl/segment_tree_range_sum_assert.svh */
// Assertion macros used by the block's top-level RTL file.
`ifndef SEGMENT_TREE_RANGE_SUM_ASSERT_SVH
`define SEGMENT_TREE_RANGE_SUM_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define STRS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define STRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/strs_pkg.sv */
package strs_pkg;

   localparam int LEAF_COUNT_DEFAULT = 1024;

   localparam int OP_W  = 2;
   localparam int IDX_W = 10;
   localparam int VAL_W = 21;
   localparam int RSP_W = 30;

   localparam logic [RSP_W-1:0] SUM_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_DEC   = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_WR,
      ST_DEC_RD,
      ST_DEC_WR,
      ST_SIB_RD,
      ST_PARENT_WR,
      ST_Q_LEFT,
      ST_Q_RIGHT
   } state_type;

   typedef enum logic [3:0] {
      MEM_NONE,
      MEM_CLEAR,
      MEM_WR_LEAF,
      MEM_RD_LEAF,
      MEM_WR_DEC,
      MEM_RD_SIB,
      MEM_WR_PARENT,
      MEM_RD_LEFT,
      MEM_RD_RIGHT
   } mem_cmd_type;

   typedef struct packed {
      mem_cmd_type mem_op;
      logic        capture;
      logic        acc_add;
      logic        left_step;
      logic        shift_step;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic idx_ok;
      logic left_odd;
      logic right_odd;
      logic loop_go;
      logic rd_zero;
      logic path_more;
      logic clr_last;
   } sts_type;

endpackage

/* rtl/strs_ctrl.sv */
module strs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [strs_pkg::OP_W-1:0]  req_op,
   input  strs_pkg::sts_type          sts,
   output strs_pkg::cmd_type          cmd,
   output logic                       busy,
   output logic                       rsp_valid
);

   strs_pkg::state_type state_ff, state_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= strs_pkg::ST_CLEAR;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         strs_pkg::ST_CLEAR: begin
            if (sts.clr_last) state_in = strs_pkg::ST_IDLE;
         end
         strs_pkg::ST_IDLE: begin
            if (start) begin
               case (strs_pkg::op_type'(req_op))
                  strs_pkg::OP_LOAD: begin
                     if (sts.idx_ok) state_in = strs_pkg::ST_LOAD_WR;
                  end
                  strs_pkg::OP_DEC: begin
                     if (sts.idx_ok) state_in = strs_pkg::ST_DEC_RD;
                  end
                  strs_pkg::OP_QUERY: state_in = strs_pkg::ST_Q_LEFT;
                  default: state_in = strs_pkg::ST_IDLE;
               endcase
            end
         end
         strs_pkg::ST_LOAD_WR: state_in = strs_pkg::ST_SIB_RD;
         strs_pkg::ST_DEC_RD:  state_in = strs_pkg::ST_DEC_WR;
         strs_pkg::ST_DEC_WR: begin
            state_in = sts.rd_zero ? strs_pkg::ST_IDLE : strs_pkg::ST_SIB_RD;
         end
         strs_pkg::ST_SIB_RD: state_in = strs_pkg::ST_PARENT_WR;
         strs_pkg::ST_PARENT_WR: begin
            state_in = sts.path_more ? strs_pkg::ST_SIB_RD : strs_pkg::ST_IDLE;
         end
         strs_pkg::ST_Q_LEFT: begin
            if (!sts.loop_go) state_in = strs_pkg::ST_IDLE;
            else state_in = strs_pkg::ST_Q_RIGHT;
         end
         strs_pkg::ST_Q_RIGHT: state_in = strs_pkg::ST_Q_LEFT;
         default: state_in = strs_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.mem_op     = strs_pkg::MEM_NONE;
      cmd.capture    = 1'b0;
      cmd.acc_add    = 1'b0;
      cmd.left_step  = 1'b0;
      cmd.shift_step = 1'b0;
      cmd.emit       = 1'b0;
      pend_in        = 1'b0;
      rsp_valid_in   = 1'b0;
      busy           = 1'b1;
      case (state_ff)
         strs_pkg::ST_CLEAR: cmd.mem_op = strs_pkg::MEM_CLEAR;
         strs_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         strs_pkg::ST_LOAD_WR: cmd.mem_op = strs_pkg::MEM_WR_LEAF;
         strs_pkg::ST_DEC_RD:  cmd.mem_op = strs_pkg::MEM_RD_LEAF;
         strs_pkg::ST_DEC_WR: begin
            // a zero leaf stays zero and the path is left alone
            if (!sts.rd_zero) cmd.mem_op = strs_pkg::MEM_WR_DEC;
         end
         strs_pkg::ST_SIB_RD:    cmd.mem_op = strs_pkg::MEM_RD_SIB;
         strs_pkg::ST_PARENT_WR: cmd.mem_op = strs_pkg::MEM_WR_PARENT;
         strs_pkg::ST_Q_LEFT: begin
            cmd.acc_add = pend_ff;
            if (sts.loop_go) begin
               cmd.mem_op    = sts.left_odd ? strs_pkg::MEM_RD_LEFT : strs_pkg::MEM_NONE;
               cmd.left_step = 1'b1;
               pend_in       = sts.left_odd;
            end else begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         strs_pkg::ST_Q_RIGHT: begin
            cmd.acc_add    = pend_ff;
            cmd.mem_op     = sts.right_odd ? strs_pkg::MEM_RD_RIGHT : strs_pkg::MEM_NONE;
            cmd.shift_step = 1'b1;
            pend_in        = sts.right_odd;
         end
         default: busy = 1'b1;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/strs_datapath.sv */
module strs_datapath #(
   parameter int LEAF_COUNT = strs_pkg::LEAF_COUNT_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [strs_pkg::IDX_W-1:0]  req_index,
   input  logic [strs_pkg::VAL_W-1:0]  req_leaf_value,
   input  logic [strs_pkg::IDX_W-1:0]  req_range_low,
   input  logic [strs_pkg::IDX_W-1:0]  req_range_high,
   input  strs_pkg::cmd_type           cmd,
   output strs_pkg::sts_type           sts,
   output logic [strs_pkg::RSP_W-1:0]  rsp_range_sum
);

   localparam int DEPTH = 2 * LEAF_COUNT;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = ((AW > strs_pkg::IDX_W) ? AW : strs_pkg::IDX_W) + 1;
   localparam int NW    = strs_pkg::VAL_W + $clog2(LEAF_COUNT);
   localparam int CW    = (NW > strs_pkg::RSP_W) ? NW : strs_pkg::RSP_W;

   localparam logic [PW-1:0] LEAVES    = PW'(LEAF_COUNT);
   localparam logic [PW-1:0] LAST_LEAF = PW'(LEAF_COUNT - 1);
   localparam logic [AW-1:0] LAST_NODE = AW'(DEPTH - 1);

   logic [NW-1:0] node_mem [DEPTH];

   logic [AW-1:0]                pos_ff, pos_in;
   logic [NW-1:0]                cur_ff, cur_in;
   logic [PW-1:0]                left_ff, left_in;
   logic [PW-1:0]                right_ff, right_in;
   logic [NW-1:0]                acc_ff, acc_in;
   logic [strs_pkg::VAL_W-1:0]   value_ff, value_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic [strs_pkg::RSP_W-1:0]   sum_ff, sum_in;
   logic [NW-1:0]                rd_ff;

   logic [PW-1:0] idx_ext, lo_ext, hi_ext, hi_clamp, pos_sum, right_dec;
   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic [NW-1:0] mem_wdata;
   logic [NW-1:0] node_sum, dec_val, acc_sum;
   logic [CW-1:0] sum_ext;

   assign idx_ext   = PW'(req_index);
   assign lo_ext    = PW'(req_range_low);
   assign hi_ext    = PW'(req_range_high);
   assign hi_clamp  = (hi_ext > LAST_LEAF) ? LAST_LEAF : hi_ext;
   assign pos_sum   = idx_ext + LEAVES;
   assign right_dec = right_ff - PW'(1);
   assign node_sum  = cur_ff + rd_ff;
   assign dec_val   = rd_ff - NW'(1);
   assign acc_sum   = acc_ff + (cmd.acc_add ? rd_ff : '0);
   assign sum_ext   = CW'(acc_sum);

   assign sts.idx_ok    = idx_ext < LEAVES;
   assign sts.left_odd  = left_ff[0];
   assign sts.right_odd = right_ff[0];
   assign sts.loop_go   = left_ff < right_ff;
   assign sts.rd_zero   = rd_ff == '0;
   assign sts.path_more = (pos_ff >> 2) != '0;
   assign sts.clr_last  = clr_ff == LAST_NODE;

   // single memory port: one read or one write per cycle
   always_comb begin
      mem_addr  = pos_ff;
      mem_we    = 1'b0;
      mem_wdata = '0;
      case (cmd.mem_op)
         strs_pkg::MEM_CLEAR: begin
            mem_addr = clr_ff;
            mem_we   = 1'b1;
         end
         strs_pkg::MEM_WR_LEAF: begin
            mem_we    = 1'b1;
            mem_wdata = NW'(value_ff);
         end
         strs_pkg::MEM_RD_LEAF: mem_addr = pos_ff;
         strs_pkg::MEM_WR_DEC: begin
            mem_we    = 1'b1;
            mem_wdata = dec_val;
         end
         strs_pkg::MEM_RD_SIB: mem_addr = pos_ff ^ AW'(1);
         strs_pkg::MEM_WR_PARENT: begin
            mem_addr  = pos_ff >> 1;
            mem_we    = 1'b1;
            mem_wdata = node_sum;
         end
         strs_pkg::MEM_RD_LEFT:  mem_addr = left_ff[AW-1:0];
         strs_pkg::MEM_RD_RIGHT: mem_addr = right_dec[AW-1:0];
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) node_mem[mem_addr] <= mem_wdata;
      rd_ff <= node_mem[mem_addr];
   end

   always_comb begin
      pos_in   = pos_ff;
      cur_in   = cur_ff;
      left_in  = left_ff;
      right_in = right_ff;
      acc_in   = acc_sum;
      value_in = value_ff;
      clr_in   = clr_ff;
      sum_in   = sum_ff;
      if (cmd.capture) begin
         pos_in   = pos_sum[AW-1:0];
         value_in = req_leaf_value;
         left_in  = lo_ext + LEAVES;
         right_in = hi_clamp + LEAVES + PW'(1);
         acc_in   = '0;
      end
      if (cmd.mem_op == strs_pkg::MEM_CLEAR) clr_in = clr_ff + AW'(1);
      if (mem_we) cur_in = mem_wdata;
      if (cmd.mem_op == strs_pkg::MEM_WR_PARENT) pos_in = pos_ff >> 1;
      if (cmd.left_step) left_in = left_ff + PW'(left_ff[0]);
      if (cmd.shift_step) begin
         left_in  = left_ff >> 1;
         right_in = (right_ff[0] ? right_dec : right_ff) >> 1;
      end
      if (cmd.emit) begin
         sum_in = (sum_ext > CW'(strs_pkg::SUM_MAX)) ? strs_pkg::SUM_MAX
                                                      : sum_ext[strs_pkg::RSP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      cur_ff   <= cur_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      acc_ff   <= acc_in;
      value_ff <= value_in;
      sum_ff   <= sum_in;
   end

   assign rsp_range_sum = sum_ff;

endmodule

/* rtl/segment_tree_range_sum.sv */
// Sum segment tree over LEAF_COUNT leaves, one command word at a time. A word is
// taken when start is high and busy is low; req_op picks load (set a leaf), decrement
// (lower a leaf by one, never below zero) or query (sum of leaves range_low through
// range_high, clamped to the last leaf, zero when the range is empty). Only a query
// answers: rsp_valid pulses for exactly one cycle with rsp_range_sum, saturated at
// 2^30-1, and the receiver cannot stall it, so capture it on that cycle. Loads,
// decrements, an out-of-range leaf index and the unused op code give no response.
// After reset the block holds busy while it zeroes the node memory. All node sums
// live in one single-port memory that does one read or one write per cycle, and that
// port sets the pace: a load writes the leaf, a decrement reads the leaf and writes
// it back lowered (stopping there when it is already zero), and both then walk to the
// root, reading the sibling and writing the parent at each level; a query reads the
// range's edge nodes level by level, its response showing on the cycle busy drops.
`include "segment_tree_range_sum_assert.svh"

module segment_tree_range_sum #(
   parameter int LEAF_COUNT = strs_pkg::LEAF_COUNT_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [strs_pkg::OP_W-1:0]   req_op,
   input  logic [strs_pkg::IDX_W-1:0]  req_index,
   input  logic [strs_pkg::VAL_W-1:0]  req_leaf_value,
   input  logic [strs_pkg::IDX_W-1:0]  req_range_low,
   input  logic [strs_pkg::IDX_W-1:0]  req_range_high,
   output logic                        rsp_valid,
   output logic [strs_pkg::RSP_W-1:0]  rsp_range_sum
);

   strs_pkg::cmd_type cmd;
   strs_pkg::sts_type sts;

   // sequence the clear pass, the leaf-to-root update walk and the query climb
   strs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_op),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // node memory, path and range pointers, running sum and response register
   strs_datapath #(
      .LEAF_COUNT (LEAF_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_index      (req_index),
      .req_leaf_value (req_leaf_value),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_range_sum  (rsp_range_sum)
   );

   // a response lands on the cycle the block goes idle again
   `STRS_ASSERT_NOW(a_rsp_when_idle, rsp_valid, !busy, "response while busy")
   `STRS_ASSERT_NOW(a_rsp_after_work, rsp_valid, $past(busy), "response without a query")
   // a query always leaves idle and walks the tree before it answers
   `STRS_ASSERT_NEXT(a_query_busy, start && !busy && (req_op == strs_pkg::OP_QUERY),
      busy && !rsp_valid, "query finished without walking the tree")

endmodule
